/* src/peer_table_rssi_tracker_macros.svh */
// Assertion macros shared by the peer table checker
`ifndef PEER_TABLE_RSSI_TRACKER_MACROS_SVH
`define PEER_TABLE_RSSI_TRACKER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define PTRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define PTRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ptrt_pkg.sv */
// Types, constants and codes of the peer table tracker
package ptrt_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W = 48;
  localparam int STR_W  = 8;
  localparam int TIME_W = 32;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 112;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic signed [STR_W-1:0] THR_RESET = -8'sd90;
  localparam logic signed [STR_W-1:0] FLOOR_STRENGTH = -8'sd128;

  localparam logic [1:0] MODE_REPORT = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [2:0] ST_WEAK    = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_ADDED   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;
  localparam logic [2:0] ST_HIT     = 3'd5;
  localparam logic [2:0] ST_MISS    = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic signed [STR_W-1:0]  strength;
    logic                     target;
    logic [TIME_W-1:0]        last_seen;
  } entry_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic [ADDR_W-1:0]        addr;
    logic signed [STR_W-1:0]  strength;
    logic                     target;
    logic [TIME_W-1:0]        stamp;
  } item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [2:0]               slot;
    logic signed [STR_W-1:0]  hit_strength;
    logic                     hit_target;
    logic [TIME_W-1:0]        hit_time;
    logic [3:0]               peer_count;
    logic                     nearest_valid;
    logic [2:0]               nearest_slot;
    logic signed [STR_W-1:0]  nearest_strength;
    logic [ADDR_W-1:0]        nearest_address;
  } result_t;

endpackage

/* src/ptrt_mem.sv */
// Entry memory: one write port, one registered read port
module ptrt_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ptrt_pkg::IDX_W-1:0]  wr_addr,
  input  ptrt_pkg::entry_t            wr_data,
  input  logic                        rd_en,
  input  logic [ptrt_pkg::IDX_W-1:0]  rd_addr,
  output ptrt_pkg::entry_t            rd_data
);
  import ptrt_pkg::*;

  entry_t mem_r [TABLE_ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rdata_r;

endmodule

/* src/ptrt_cfg.sv */
// Configuration registers behind the APB-style port
module ptrt_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ptrt_pkg::CFG_AW-1:0]       paddr,
  input  logic [ptrt_pkg::CFG_DW-1:0]       pwdata,
  output logic [ptrt_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready,
  output logic signed [ptrt_pkg::STR_W-1:0] threshold
);
  import ptrt_pkg::*;

  logic signed [STR_W-1:0] thr_r;
  logic signed [STR_W-1:0] thr_nxt;
  logic                    sel_thr;

  assign sel_thr = (paddr[CFG_AW-1] == REG_THRESHOLD);
  assign pready  = 1'b1;

  always_comb begin
    thr_nxt = thr_r;
    if (psel && penable && pwrite && pready && sel_thr) begin
      thr_nxt = pwdata[STR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign prdata    = sel_thr ? {{(CFG_DW-STR_W){thr_r[STR_W-1]}}, thr_r} : '0;
  assign threshold = thr_r;

endmodule

/* src/ptrt_seq.sv */
// Sequencer: walks the entry memory for match, free slot and strongest target
module ptrt_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [ptrt_pkg::STR_W-1:0] threshold,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  ptrt_pkg::item_t                   item,
  output logic                              res_valid,
  input  logic                              res_ready,
  output ptrt_pkg::result_t                 res,
  output logic                              mem_wr_en,
  output logic [ptrt_pkg::IDX_W-1:0]        mem_wr_addr,
  output ptrt_pkg::entry_t                  mem_wr_data,
  output logic                              mem_rd_en,
  output logic [ptrt_pkg::IDX_W-1:0]        mem_rd_addr,
  input  ptrt_pkg::entry_t                  mem_rd_data
);
  import ptrt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_NEAR = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]               state_r,     state_nxt;
  item_t                    item_r,      item_nxt;
  logic [2:0]               status_r,    status_nxt;
  logic [IDX_W-1:0]         slot_r,      slot_nxt;
  logic [CNT_W-1:0]         cnt_r,       cnt_nxt;
  logic                     ev_vld_r,    ev_vld_nxt;
  logic [IDX_W-1:0]         ev_idx_r,    ev_idx_nxt;
  logic                     mfnd_r,      mfnd_nxt;
  logic [IDX_W-1:0]         midx_r,      midx_nxt;
  logic                     ffnd_r,      ffnd_nxt;
  logic [IDX_W-1:0]         fidx_r,      fidx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r,     valid_nxt;
  logic [CNT_W-1:0]         count_r,     count_nxt;
  logic                     bfnd_r,      bfnd_nxt;
  logic [IDX_W-1:0]         bidx_r,      bidx_nxt;
  logic signed [STR_W-1:0]  bstr_r,      bstr_nxt;
  logic [ADDR_W-1:0]        baddr_r,     baddr_nxt;
  logic signed [STR_W-1:0]  hstr_r,      hstr_nxt;
  logic                     htgt_r,      htgt_nxt;
  logic [TIME_W-1:0]        htime_r,     htime_nxt;
  logic                     out_vld_r,   out_vld_nxt;
  result_t                  out_r,       out_nxt;

  logic                     accept;
  logic                     last_ev;
  logic                     e_valid;
  logic [7:0]               cnt8;
  result_t                  fin;

  assign item_ready = (state_r == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign last_ev    = ev_vld_r && (ev_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign e_valid    = valid_r[ev_idx_r];
  assign cnt8       = 8'(count_r);

  always_comb begin
    fin                  = '0;
    fin.status           = status_r;
    fin.peer_count       = (cnt8 > 8'd15) ? 4'd15 : cnt8[3:0];
    if (status_r == ST_UPDATED || status_r == ST_ADDED || status_r == ST_HIT) begin
      fin.slot = 3'(slot_r);
    end
    if (status_r == ST_HIT) begin
      fin.hit_strength = hstr_r;
      fin.hit_target   = htgt_r;
      fin.hit_time     = htime_r;
    end
    if (bfnd_r) begin
      fin.nearest_valid    = 1'b1;
      fin.nearest_slot     = 3'(bidx_r);
      fin.nearest_strength = bstr_r;
      fin.nearest_address  = baddr_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    status_nxt  = status_r;
    slot_nxt    = slot_r;
    cnt_nxt     = cnt_r;
    ev_vld_nxt  = 1'b0;
    ev_idx_nxt  = ev_idx_r;
    mfnd_nxt    = mfnd_r;
    midx_nxt    = midx_r;
    ffnd_nxt    = ffnd_r;
    fidx_nxt    = fidx_r;
    valid_nxt   = valid_r;
    count_nxt   = count_r;
    bfnd_nxt    = bfnd_r;
    bidx_nxt    = bidx_r;
    bstr_nxt    = bstr_r;
    baddr_nxt   = baddr_r;
    hstr_nxt    = hstr_r;
    htgt_nxt    = htgt_r;
    htime_nxt   = htime_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !res_ready;
    mem_wr_en   = 1'b0;
    mem_wr_addr = slot_r;
    mem_wr_data = '{addr: item_r.addr, strength: item_r.strength,
                    target: item_r.target, last_seen: item_r.stamp};
    mem_rd_en   = 1'b0;
    mem_rd_addr = cnt_r[IDX_W-1:0];

    // issue one read a cycle during either walk
    if ((state_r == S_SCAN || state_r == S_NEAR) && cnt_r < CNT_W'(TABLE_ENTRIES)) begin
      mem_rd_en  = 1'b1;
      cnt_nxt    = cnt_r + 1'b1;
      ev_vld_nxt = 1'b1;
      ev_idx_nxt = cnt_r[IDX_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt   = item;
          status_nxt = ST_WEAK;
          slot_nxt   = '0;
          cnt_nxt    = '0;
          mfnd_nxt   = 1'b0;
          ffnd_nxt   = 1'b0;
          hstr_nxt   = '0;
          htgt_nxt   = 1'b0;
          htime_nxt  = '0;
          bfnd_nxt   = 1'b0;
          bstr_nxt   = FLOOR_STRENGTH;
          state_nxt  = S_NEAR;
          case (item.mode)
            MODE_REPORT: begin
              if ($signed(item.strength) >= $signed(threshold)) begin
                state_nxt = S_SCAN;
              end
            end
            MODE_CLEAR: begin
              valid_nxt  = '0;
              count_nxt  = '0;
              status_nxt = ST_CLEARED;
            end
            MODE_LOOKUP: begin
              state_nxt = S_SCAN;
            end
            default: begin
              status_nxt = ST_WEAK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ev_vld_r) begin
          if (e_valid && mem_rd_data.addr == item_r.addr && !mfnd_r) begin
            mfnd_nxt = 1'b1;
            midx_nxt = ev_idx_r;
          end
          if (!e_valid && !ffnd_r) begin
            ffnd_nxt = 1'b1;
            fidx_nxt = ev_idx_r;
          end
        end
        if (last_ev) begin
          cnt_nxt   = '0;
          state_nxt = S_NEAR;
          if (item_r.mode == MODE_LOOKUP) begin
            status_nxt = mfnd_nxt ? ST_HIT : ST_MISS;
            slot_nxt   = midx_nxt;
          end else if (mfnd_nxt) begin
            status_nxt = ST_UPDATED;
            slot_nxt   = midx_nxt;
            state_nxt  = S_WR;
          end else if (count_r < CNT_W'(TABLE_ENTRIES) && ffnd_nxt) begin
            status_nxt = ST_ADDED;
            slot_nxt   = fidx_nxt;
            state_nxt  = S_WR;
          end else begin
            status_nxt = ST_FULL;
          end
        end
      end
      S_WR: begin
        mem_wr_en = 1'b1;
        if (status_r == ST_ADDED) begin
          valid_nxt[slot_r] = 1'b1;
          count_nxt         = count_r + 1'b1;
        end
        cnt_nxt   = '0;
        state_nxt = S_NEAR;
      end
      S_NEAR: begin
        if (ev_vld_r) begin
          if (e_valid && mem_rd_data.target &&
              $signed(mem_rd_data.strength) > $signed(bstr_r)) begin
            bfnd_nxt  = 1'b1;
            bidx_nxt  = ev_idx_r;
            bstr_nxt  = mem_rd_data.strength;
            baddr_nxt = mem_rd_data.addr;
          end
          if (status_r == ST_HIT && ev_idx_r == slot_r) begin
            hstr_nxt  = mem_rd_data.strength;
            htgt_nxt  = mem_rd_data.target;
            htime_nxt = mem_rd_data.last_seen;
          end
        end
        if (last_ev) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_r || res_ready) begin
          out_nxt     = fin;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ev_vld_r  <= 1'b0;
      valid_r   <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      ev_vld_r  <= ev_vld_nxt;
      valid_r   <= valid_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    ev_idx_r <= ev_idx_nxt;
    mfnd_r   <= mfnd_nxt;
    midx_r   <= midx_nxt;
    ffnd_r   <= ffnd_nxt;
    fidx_r   <= fidx_nxt;
    bfnd_r   <= bfnd_nxt;
    bidx_r   <= bidx_nxt;
    bstr_r   <= bstr_nxt;
    baddr_r  <= baddr_nxt;
    hstr_r   <= hstr_nxt;
    htgt_r   <= htgt_nxt;
    htime_r  <= htime_nxt;
    out_r    <= out_nxt;
  end

  assign res_valid = out_vld_r;
  assign res       = out_r;

endmodule

/* src/peer_table_rssi_tracker.sv */
// Peer table tracker top level: stream ports, configuration port, entry memory
// Keeps up to TABLE_ENTRIES (8) radio peers keyed by 48-bit address and answers
// one result per input transfer. Items are handled one at a time: a report that
// updates or adds an entry walks the entry memory for match and free slot, writes
// the entry and walks it again for the strongest target; a lookup or a report dropped
// on a full table makes both walks without the write, and a clear, a weak report or an
// unused mode only the second walk. The walks follow from the single read port of the
// entry memory. A result that finds the output register still occupied waits there
// until the previous result is taken. Valid flags sit in flip-flops, so reset and
// clear take effect at once with no clearing pass. A finished result waits in an
// output register while the next item is accepted, in the cycle after the result is
// loaded.
module peer_table_rssi_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // peer_address[47:0], signal_strength[55:48], is_target[56], timestamp[88:57]
  input  logic [ptrt_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode[1:0]
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // slot[2:0], hit_strength[10:3], hit_target[11], hit_time[43:12],
  // peer_count[47:44], nearest_valid[48], nearest_slot[51:49],
  // nearest_strength[59:52], nearest_address[107:60]
  output logic [ptrt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[2:0]
  output logic [2:0]                        out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ptrt_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [ptrt_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [ptrt_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import ptrt_pkg::*;

  logic signed [STR_W-1:0] threshold;
  item_t                   item;
  result_t                 res;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  entry_t                  wr_data;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  entry_t                  rd_data;

  assign item.mode     = in_tuser;
  assign item.addr     = in_tdata[47:0];
  assign item.strength = in_tdata[55:48];
  assign item.target   = in_tdata[56];
  assign item.stamp    = in_tdata[88:57];

  ptrt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .threshold (threshold)
  );

  ptrt_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ptrt_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .threshold   (threshold),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .item        (item),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data)
  );

  assign out_tuser = res.status;
  assign out_tdata = {4'b0, res.nearest_address, res.nearest_strength, res.nearest_slot,
                      res.nearest_valid, res.peer_count, res.hit_time, res.hit_target,
                      res.hit_strength, res.slot};

endmodule

/* src/ptrt_chk.sv */
// Port-level checker for the peer table tracker, bound to the top level
`include "peer_table_rssi_tracker_macros.svh"

module ptrt_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ptrt_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [2:0]                        out_tuser
);
  import ptrt_pkg::*;

  `PTRT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  `PTRT_ASSERT_NOW(a_count_max, out_tvalid,
    out_tdata[47:44] <= 4'(TABLE_ENTRIES), "peer count above table size")

  `PTRT_ASSERT_NOW(a_near_zero, out_tvalid && !out_tdata[48],
    out_tdata[107:49] == '0, "nearest fields set without a nearest entry")

  `PTRT_ASSERT_NOW(a_clear_empty, out_tvalid && out_tuser == ST_CLEARED,
    out_tdata[48:44] == '0, "table not empty after clear")

  `PTRT_ASSERT_NOW(a_hit_only, out_tvalid && out_tuser != ST_HIT,
    out_tdata[43:3] == '0, "hit fields set on a non-hit result")

endmodule

bind peer_table_rssi_tracker ptrt_chk u_ptrt_chk (.*);

/* bench/tb_peer_table_rssi_tracker.sv */
`timescale 1ns / 100ps
// Self-checking bench for the peer table tracker: directed and random peer traffic
module tb_peer_table_rssi_tracker;
  import ptrt_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 30;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int POOL_SIZE = 12;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_AW-1:0] THR_ADDR = CFG_AW'(4 * REG_THRESHOLD);

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [CFG_DW-1:0]     cfg_pwdata;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  peer_table_rssi_tracker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicted peer table
  bit                      tbl_valid [TABLE_ENTRIES];
  logic [ADDR_W-1:0]       tbl_addr  [TABLE_ENTRIES];
  logic signed [STR_W-1:0] tbl_str   [TABLE_ENTRIES];
  bit                      tbl_tgt   [TABLE_ENTRIES];
  logic [TIME_W-1:0]       tbl_seen  [TABLE_ENTRIES];
  int unsigned             peer_total;
  logic signed [STR_W-1:0] thr;

  result_t           expected_results [$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  int                mismatches;
  int                cycle_count;
  int                rdy_hold;
  bit                idle_on;
  result_t           got;
  result_t           want;

  always #6 clk = ~clk;

  function automatic void wipe_peer_table();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i]  = '0;
      tbl_str[i]   = '0;
      tbl_tgt[i]   = 1'b0;
      tbl_seen[i]  = '0;
    end
    peer_total = 0;
  endfunction

  function automatic result_t predict_peer_result(input item_t it);
    result_t                 r;
    int                      hit;
    int                      pos;
    int                      best;
    logic signed [STR_W-1:0] best_str;
    r = '0;
    r.status = ST_WEAK;
    hit = -1;
    pos = 0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_addr[i] == it.addr) hit = i;
    case (it.mode)
      MODE_REPORT: begin
        if (it.strength >= thr) begin
          if (hit >= 0) begin
            r.status = ST_UPDATED;
            pos = hit;
          end else if (peer_total < TABLE_ENTRIES) begin
            while (tbl_valid[pos]) pos++;
            r.status = ST_ADDED;
            tbl_valid[pos] = 1'b1;
            tbl_addr[pos] = it.addr;
            peer_total++;
          end else begin
            r.status = ST_FULL;
          end
          if (r.status != ST_FULL) begin
            tbl_str[pos] = it.strength;
            tbl_seen[pos] = it.stamp;
            tbl_tgt[pos] = it.target;
            r.slot = 3'(pos);
          end
        end
      end
      MODE_CLEAR: begin
        wipe_peer_table();
        r.status = ST_CLEARED;
      end
      MODE_LOOKUP: begin
        if (hit >= 0) begin
          r.status = ST_HIT;
          r.slot = 3'(hit);
          r.hit_strength = tbl_str[hit];
          r.hit_target = tbl_tgt[hit];
          r.hit_time = tbl_seen[hit];
        end else begin
          r.status = ST_MISS;
        end
      end
      default: ;
    endcase
    best = -1;
    best_str = FLOOR_STRENGTH;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_tgt[i] && tbl_str[i] > best_str) begin
        best = i;
        best_str = tbl_str[i];
      end
    end
    r.peer_count = (peer_total > 15) ? 4'd15 : 4'(peer_total);
    if (best >= 0) begin
      r.nearest_valid = 1'b1;
      r.nearest_slot = 3'(best);
      r.nearest_strength = best_str;
      r.nearest_address = tbl_addr[best];
    end
    return r;
  endfunction

  function automatic string show_result(input result_t r);
    return $sformatf({"status=%0d slot=%0d hit_str=%0d hit_tgt=%0d hit_time=%h count=%0d ",
                      "near_valid=%0d near_slot=%0d near_str=%0d near_addr=%h"},
                     r.status, r.slot, r.hit_strength, r.hit_target, r.hit_time,
                     r.peer_count, r.nearest_valid, r.nearest_slot, r.nearest_strength,
                     r.nearest_address);
  endfunction

  function automatic item_t mk_item(input logic [1:0] m, input logic [ADDR_W-1:0] a,
                                    input logic signed [STR_W-1:0] s, input logic t,
                                    input logic [TIME_W-1:0] ts);
    item_t it;
    it.mode = m;
    it.addr = a;
    it.strength = s;
    it.target = t;
    it.stamp = ts;
    return it;
  endfunction

  function automatic item_t random_peer_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 68)      it.mode = MODE_REPORT;
    else if (pick < 88) it.mode = MODE_LOOKUP;
    else if (pick < 91) it.mode = MODE_CLEAR;
    else if (pick < 94) it.mode = MODE_SPARE;
    else                it.mode = MODE_REPORT;
    if (pick >= 94) it.addr = 48'({$urandom, $urandom});
    else            it.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 4) == 0) it.strength = thr;
    else                           it.strength = 8'($urandom);
    it.target = 1'($urandom_range(0, 1));
    it.stamp = $urandom;
    return it;
  endfunction

  task automatic send_peer_item(input item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = '0;
    in_tdata[47:0] = it.addr;
    in_tdata[55:48] = it.strength;
    in_tdata[56] = it.target;
    in_tdata[88:57] = it.stamp;
    in_tuser = it.mode;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_peer_result(it));
    @(negedge clk);
  endtask

  task automatic wait_table_idle();
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // write the threshold, then read it back
  task automatic write_threshold(input logic signed [STR_W-1:0] level);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = THR_ADDR;
    cfg_pwdata = {{(CFG_DW - STR_W){level[STR_W-1]}}, level};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    thr = level;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[STR_W-1:0] !== level) begin
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
        $display("threshold readback: expected %0d actual %0d", level,
                 $signed(cfg_prdata[STR_W-1:0]));
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic test_basic_table();
    send_peer_item(mk_item(MODE_LOOKUP, 48'h0, 0, 1'b0, 32'h0));
    send_peer_item(mk_item(MODE_REPORT, 48'h1234_5678_9ABC, -91, 1'b1, 32'h10));
    send_peer_item(mk_item(MODE_REPORT, 48'h0, -90, 1'b1, 32'h0));
    send_peer_item(mk_item(MODE_REPORT, 48'hFFFF_FFFF_FFFF, 127, 1'b1, 32'hFFFF_FFFF));
    send_peer_item(mk_item(MODE_REPORT, 48'hFFFF_FFFF_FFFF, -50, 1'b0, 32'h1234_5678));
    send_peer_item(mk_item(MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 0, 1'b0, 32'h0));
    send_peer_item(mk_item(MODE_SPARE, 48'hAAAA_5555_AAAA, 127, 1'b1, 32'hAAAA_5555));
    send_peer_item(mk_item(MODE_REPORT, 48'h5555_AAAA_5555, -50, 1'b1, 32'h20));
    // equal strength: lowest slot keeps nearest
    send_peer_item(mk_item(MODE_REPORT, 48'h8000_0000_0001, -50, 1'b1, 32'h8000_0000));
    for (int i = 4; i < TABLE_ENTRIES; i++)
      send_peer_item(mk_item(MODE_REPORT, 48'(32'h1000 + i), 8'(-60 + i), 1'(i % 2),
                             32'(i)));
    send_peer_item(mk_item(MODE_REPORT, 48'h7777_7777_7777, 100, 1'b1, 32'h77));
    send_peer_item(mk_item(MODE_REPORT, 48'h0, 0, 1'b1, 32'h55));
    send_peer_item(mk_item(MODE_LOOKUP, 48'h1005, 0, 1'b0, 32'h0));
    send_peer_item(mk_item(MODE_CLEAR, 48'h0, 0, 1'b0, 32'h0));
    send_peer_item(mk_item(MODE_LOOKUP, 48'h0, 0, 1'b0, 32'h0));
    send_peer_item(mk_item(MODE_REPORT, 48'hA5A5_A5A5_A5A5, -10, 1'b1, 32'h5A5A_5A5A));
  endtask

  task automatic test_threshold_extremes();
    wait_table_idle();
    write_threshold(FLOOR_STRENGTH);
    send_peer_item(mk_item(MODE_CLEAR, 48'h0, 0, 1'b0, 32'h0));
    // floor strength is stored but never nearest
    send_peer_item(mk_item(MODE_REPORT, 48'hF0, FLOOR_STRENGTH, 1'b1, 32'h1));
    send_peer_item(mk_item(MODE_LOOKUP, 48'hF0, 0, 1'b0, 32'h0));
    send_peer_item(mk_item(MODE_REPORT, 48'hF1, -127, 1'b1, 32'h2));
    wait_table_idle();
    write_threshold(127);
    send_peer_item(mk_item(MODE_REPORT, 48'hF2, 126, 1'b1, 32'h3));
    send_peer_item(mk_item(MODE_REPORT, 48'hF3, 127, 1'b1, 32'h4));
    send_peer_item(mk_item(MODE_REPORT, 48'hF0, 127, 1'b0, 32'h5));
    wait_table_idle();
    write_threshold(THR_RESET);
  endtask

  task automatic test_random_traffic();
    logic signed [STR_W-1:0] level;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = 48'({$urandom, $urandom});
    for (int phase = 0; phase < 10; phase++) begin
      wait_table_idle();
      case (phase)
        0:       level = FLOOR_STRENGTH;
        1:       level = 127;
        2:       level = THR_RESET;
        default: level = 8'($urandom_range(0, 90) - 110);
      endcase
      write_threshold(level);
      idle_on = (phase % 3) != 2;
      repeat ((phase == 1) ? 30 : 110) send_peer_item(random_peer_item());
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rdy_hold > 0) begin
      out_tready = 1'b0;
      rdy_hold--;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.slot = out_tdata[2:0];
      got.hit_strength = out_tdata[10:3];
      got.hit_target = out_tdata[11];
      got.hit_time = out_tdata[43:12];
      got.peer_count = out_tdata[47:44];
      got.nearest_valid = out_tdata[48];
      got.nearest_slot = out_tdata[51:49];
      got.nearest_strength = out_tdata[59:52];
      got.nearest_address = out_tdata[107:60];
      rdy_hold = idle_on ? $urandom_range(0, 5) : 0;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected result: %s", show_result(got));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.hit_strength !== want.hit_strength || got.hit_target !== want.hit_target ||
            got.hit_time !== want.hit_time || got.peer_count !== want.peer_count ||
            got.nearest_valid !== want.nearest_valid ||
            got.nearest_slot !== want.nearest_slot ||
            got.nearest_strength !== want.nearest_strength ||
            got.nearest_address !== want.nearest_address) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(got));
          end
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idle_on = 1'b1;
    rdy_hold = 0;
    mismatches = 0;
    cycle_count = 0;
    wipe_peer_table();
    thr = THR_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_basic_table();
    test_threshold_extremes();
    test_random_traffic();
    wait_table_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
